### hw/rtl/lfss_pkg.sv
// Shared types and constants for the largest free square scan.
package lfss_pkg;

  // Fixed field widths
  localparam int SIDE_W     = 11;
  localparam int POS_W      = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 4'd1;

  // Side saturates here
  localparam logic [SIDE_W-1:0] SIDE_MAX = 11'h7FF;

  // Where a cell sits in the scan
  typedef struct packed {
    logic last_row;   // bottom row of the map
    logic last_col;   // rightmost column of the map
    logic map_first;  // first cell scanned in a map (bottom right)
    logic map_last;   // final cell of a map (row 0, column 0)
  } scan_flags_t;

endpackage

### hw/rtl/lfss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfss_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

### hw/rtl/lfss_pos.sv
// Map geometry registers and the reverse raster position counters.
module lfss_pos #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lfss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           adv,
  output logic [RW-1:0]                  row,
  output logic [CW-1:0]                  col,
  output lfss_pkg::scan_flags_t          flags
);
  localparam int RST_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
  localparam int RST_COLS = (MAX_COLS < 1024) ? MAX_COLS : 1024;

  logic [RW-1:0] last_row_r, last_row_nxt;
  logic [CW-1:0] last_col_r, last_col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [31:0]   data_ext;
  logic [31:0]   rows_eff;
  logic [31:0]   cols_eff;

  // Clamp written counts into 1..MAX
  always_comb begin
    data_ext = 32'(cfg_data);
    if (data_ext == 32'd0) begin
      rows_eff = 32'd1;
      cols_eff = 32'd1;
    end else begin
      rows_eff = (data_ext > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : data_ext;
      cols_eff = (data_ext > 32'(MAX_COLS)) ? 32'(MAX_COLS) : data_ext;
    end
  end

  // Geometry update and scan restart, else step one cell back
  always_comb begin
    last_row_nxt = last_row_r;
    last_col_nxt = last_col_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    if (cfg_we && (cfg_index == lfss_pkg::REG_ROWS_IN_USE)) begin
      last_row_nxt = RW'(rows_eff - 32'd1);
      row_nxt      = RW'(rows_eff - 32'd1);
      col_nxt      = last_col_r;
    end else if (cfg_we && (cfg_index == lfss_pkg::REG_COLS_IN_USE)) begin
      last_col_nxt = CW'(cols_eff - 32'd1);
      row_nxt      = last_row_r;
      col_nxt      = CW'(cols_eff - 32'd1);
    end else if (adv) begin
      if (col_r == '0) begin
        col_nxt = last_col_r;
        row_nxt = (row_r == '0) ? last_row_r : row_r - RW'(1);
      end else begin
        col_nxt = col_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= RW'(RST_ROWS - 1);
      last_col_r <= CW'(RST_COLS - 1);
      row_r      <= RW'(RST_ROWS - 1);
      col_r      <= CW'(RST_COLS - 1);
    end else begin
      last_row_r <= last_row_nxt;
      last_col_r <= last_col_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
    end
  end

  assign row             = row_r;
  assign col             = col_r;
  assign flags.last_row  = (row_r == last_row_r);
  assign flags.last_col  = (col_r == last_col_r);
  assign flags.map_first = (row_r == last_row_r) && (col_r == last_col_r);
  assign flags.map_last  = (row_r == '0) && (col_r == '0);
endmodule

### hw/rtl/lfss_core.sv
// Side computation stage, best tracking and the output register.
module lfss_core #(
  parameter int RW = 10,
  parameter int CW = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // new cell from the input side
  input  logic                          in_fire,
  input  logic                          in_free,
  input  logic [RW-1:0]                 in_row,
  input  logic [CW-1:0]                 in_col,
  input  lfss_pkg::scan_flags_t         in_flags,
  output logic                          in_hold,
  // row store write side and read data
  output logic                          ram_we,
  output logic [CW-1:0]                 ram_waddr,
  output logic [lfss_pkg::SIDE_W-1:0]   ram_wdata,
  input  logic [lfss_pkg::SIDE_W-1:0]   ram_rdata,
  // result beat
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfss_pkg::SIDE_W-1:0]   out_cell_side,
  output logic [lfss_pkg::SIDE_W-1:0]   out_best_side,
  output logic [lfss_pkg::POS_W-1:0]    out_best_row,
  output logic [lfss_pkg::POS_W-1:0]    out_best_col,
  output logic                          out_map_done
);
  localparam int SW = lfss_pkg::SIDE_W;

  // compute stage
  logic                  s1_valid_r;
  logic                  s1_free_r;
  logic [RW-1:0]         s1_row_r;
  logic [CW-1:0]         s1_col_r;
  lfss_pkg::scan_flags_t s1_flags_r;
  logic                  s1_fwd_r;
  logic [SW-1:0]         fwd_side_r;

  // neighbor and best state
  logic [SW-1:0]         right_r;
  logic [SW-1:0]         diag_r;
  logic [SW-1:0]         best_side_r, best_side_nxt;
  logic [RW-1:0]         best_row_r, best_row_nxt;
  logic [CW-1:0]         best_col_r, best_col_nxt;

  // output register
  logic                  out_valid_r;
  logic [SW-1:0]         out_side_r;
  logic                  out_done_r;

  logic                  s1_adv;
  logic [SW-1:0]         below;
  logic [SW-1:0]         min_val;
  logic [SW-1:0]         side;

  assign s1_adv  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_hold = s1_valid_r && out_valid_r && out_stall;

  // Below value: bypass the write that lands on the same edge as the read
  assign below = s1_fwd_r ? fwd_side_r : ram_rdata;

  // Side of this cell
  always_comb begin
    min_val = diag_r;
    if (below < min_val) begin
      min_val = below;
    end
    if (right_r < min_val) begin
      min_val = right_r;
    end
    if (!s1_free_r) begin
      side = '0;
    end else if (s1_flags_r.last_row || s1_flags_r.last_col) begin
      side = SW'(1);
    end else if (min_val == lfss_pkg::SIDE_MAX) begin
      side = lfss_pkg::SIDE_MAX;
    end else begin
      side = min_val + SW'(1);
    end
  end

  // Best so far, cleared on the first cell of a map; ties go to this cell
  always_comb begin
    if (s1_flags_r.map_first) begin
      best_side_nxt = '0;
      best_row_nxt  = '0;
      best_col_nxt  = '0;
    end else begin
      best_side_nxt = best_side_r;
      best_row_nxt  = best_row_r;
      best_col_nxt  = best_col_r;
    end
    if (s1_free_r && (side >= best_side_nxt)) begin
      best_side_nxt = side;
      best_row_nxt  = s1_row_r;
      best_col_nxt  = s1_col_r;
    end
  end

  // Row store write-back
  assign ram_we    = s1_adv;
  assign ram_waddr = s1_col_r;
  assign ram_wdata = side;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      right_r     <= '0;
      diag_r      <= '0;
      best_side_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        right_r     <= side;
        diag_r      <= below;
        best_side_r <= best_side_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_free_r  <= in_free;
      s1_row_r   <= in_row;
      s1_col_r   <= in_col;
      s1_flags_r <= in_flags;
      s1_fwd_r   <= s1_adv && (s1_col_r == in_col);
    end
    if (s1_adv) begin
      fwd_side_r <= side;
      out_side_r <= side;
      out_done_r <= s1_flags_r.map_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_side = out_side_r;
  assign out_best_side = best_side_r;
  assign out_best_row  = lfss_pkg::POS_W'(best_row_r);
  assign out_best_col  = lfss_pkg::POS_W'(best_col_r);
  assign out_map_done  = out_done_r;
endmodule

### hw/rtl/largest_free_square_scan.sv
// Top level of the largest free square scan over a reverse raster cell stream.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_stall  in_cell_free
//   out      out        out_valid / out_stall out_cell_side, out_best_side,
//                                            out_best_row, out_best_col, out_map_done
//
// One cell a cycle while out_stall does not hold the compute stage; the row store is
// read at the cell beat edge, then compute and write-back load the output register.
// Same-column write/read on one edge (single-column maps) is bypassed.
// Synchronous reset restores a 1024 x 1024 map (clamped to the maximums) and
// restarts the scan; the row store is not cleared.
// An output stall holds the compute stage and then back-pressures in_stall.
module largest_free_square_scan #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lfss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cell_free,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lfss_pkg::SIDE_W-1:0]     out_cell_side,
  output logic [lfss_pkg::SIDE_W-1:0]     out_best_side,
  output logic [lfss_pkg::POS_W-1:0]      out_best_row,
  output logic [lfss_pkg::POS_W-1:0]      out_best_col,
  output logic                            out_map_done
);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic                          in_fire;
  logic                          hold;
  logic [RW-1:0]                 cur_row;
  logic [CW-1:0]                 cur_col;
  lfss_pkg::scan_flags_t         cur_flags;
  logic                          ram_we;
  logic [CW-1:0]                 ram_waddr;
  logic [lfss_pkg::SIDE_W-1:0]   ram_wdata;
  logic [lfss_pkg::SIDE_W-1:0]   ram_rdata;

  assign in_stall = hold;
  assign in_fire  = in_valid && !hold;

  // Geometry and scan position
  lfss_pos #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (in_fire),
    .row       (cur_row),
    .col       (cur_col),
    .flags     (cur_flags)
  );

  // Row store: sides of the row below, one entry per column
  lfss_ram #(
    .WIDTH (lfss_pkg::SIDE_W),
    .DEPTH (MAX_COLS)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  // Side computation, best tracking, result register
  lfss_core #(
    .RW (RW),
    .CW (CW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_free       (in_cell_free),
    .in_row        (cur_row),
    .in_col        (cur_col),
    .in_flags      (cur_flags),
    .in_hold       (hold),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_side (out_cell_side),
    .out_best_side (out_best_side),
    .out_best_row  (out_best_row),
    .out_best_col  (out_best_col),
    .out_map_done  (out_map_done)
  );
endmodule

### test/tb_largest_free_square_scan.sv
// Testbench for largest_free_square_scan: directed table plus random maps against a predictor.
module tb_largest_free_square_scan;

  localparam int MAP_MAX_ROWS   = 1024;
  localparam int MAP_MAX_COLS   = 1024;
  localparam int RANDOM_CELLS   = 1900;
  localparam int SETTLE_CYCLES  = 4;       // quiet cycles before a register write
  localparam int DRAIN_CYCLES   = 20000;
  localparam int TIMEOUT_CYCLES = 400000;

  // Indexes with no register behind them
  localparam logic [lfss_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
    lfss_pkg::REG_COLS_IN_USE + 1'b1;
  localparam logic [lfss_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

  typedef struct packed {
    logic [lfss_pkg::SIDE_W-1:0] side;
    logic [lfss_pkg::SIDE_W-1:0] best_side;
    logic [lfss_pkg::POS_W-1:0]  best_row;
    logic [lfss_pkg::POS_W-1:0]  best_col;
    logic                        done;
  } square_res_t;

  typedef enum bit {STEP_CFG, STEP_CELL} step_kind_e;

  typedef struct {
    step_kind_e                          kind;
    logic [lfss_pkg::CFG_IDX_W-1:0]      idx;
    logic [lfss_pkg::CFG_DATA_W-1:0]     data;
    logic                                free;
    bit                                  typed;
    square_res_t                         want;
  } dir_step_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_e;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [lfss_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lfss_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_cell_free;
  logic                            out_valid;
  logic                            out_stall;
  logic [lfss_pkg::SIDE_W-1:0]     out_cell_side;
  logic [lfss_pkg::SIDE_W-1:0]     out_best_side;
  logic [lfss_pkg::POS_W-1:0]      out_best_row;
  logic [lfss_pkg::POS_W-1:0]      out_best_col;
  logic                            out_map_done;

  largest_free_square_scan #(
    .MAX_ROWS(MAP_MAX_ROWS),
    .MAX_COLS(MAP_MAX_COLS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cell_free(in_cell_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cell_side(out_cell_side),
    .out_best_side(out_best_side),
    .out_best_row(out_best_row),
    .out_best_col(out_best_col),
    .out_map_done(out_map_done)
  );

  // Predictor state: map size as written, row below, neighbors, scan position, best so far
  logic [lfss_pkg::CFG_DATA_W-1:0] map_rows_raw;
  logic [lfss_pkg::CFG_DATA_W-1:0] map_cols_raw;
  logic [lfss_pkg::SIDE_W-1:0]     below_side [MAP_MAX_COLS];
  logic [lfss_pkg::SIDE_W-1:0]     right_side;
  logic [lfss_pkg::SIDE_W-1:0]     diag_side;
  int                              scan_row;
  int                              scan_col;
  logic [lfss_pkg::SIDE_W-1:0]     top_side;
  logic [lfss_pkg::POS_W-1:0]      top_row;
  logic [lfss_pkg::POS_W-1:0]      top_col;

  square_res_t pending_squares [$];
  dir_step_t   dir_steps [$];

  int cells_sent;
  int results_seen;
  int mismatches;
  int burst_left;

  stall_mode_e stall_mode;
  int          stall_left;
  int          stall_tick;
  int          stall_period;

  square_res_t seen_square;
  square_res_t head_square;

  // Register value 0 counts as 1, anything past the maximum as the maximum
  function automatic int clamp_dim(input logic [lfss_pkg::CFG_DATA_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void restart_scan();
    scan_row = clamp_dim(map_rows_raw, MAP_MAX_ROWS) - 1;
    scan_col = clamp_dim(map_cols_raw, MAP_MAX_COLS) - 1;
  endfunction

  // One cell of the scan: side at this corner, best tracking, then step backward
  function automatic square_res_t next_square(input logic free);
    int                          rows;
    int                          cols;
    int                          r;
    int                          c;
    logic [lfss_pkg::SIDE_W-1:0] below;
    logic [lfss_pkg::SIDE_W-1:0] side;
    logic [lfss_pkg::SIDE_W-1:0] m;
    square_res_t                 res;
    rows = clamp_dim(map_rows_raw, MAP_MAX_ROWS);
    cols = clamp_dim(map_cols_raw, MAP_MAX_COLS);
    r = scan_row;
    c = scan_col;
    if (r >= rows || c >= cols) begin
      r = rows - 1;
      c = cols - 1;
    end
    // first cell of a map clears the best
    if (r == rows - 1 && c == cols - 1) begin
      top_side = '0;
      top_row  = '0;
      top_col  = '0;
    end
    below = below_side[c];
    if (!free) begin
      side = '0;
    end else if (r == rows - 1 || c == cols - 1) begin
      side = lfss_pkg::SIDE_W'(1);
    end else begin
      m = diag_side;
      if (below < m) m = below;
      if (right_side < m) m = right_side;
      side = (m == lfss_pkg::SIDE_MAX) ? lfss_pkg::SIDE_MAX : m + lfss_pkg::SIDE_W'(1);
    end
    diag_side     = below;
    below_side[c] = side;
    right_side    = side;
    // >= hands ties to the later cell
    if (free && side >= top_side) begin
      top_side = side;
      top_row  = lfss_pkg::POS_W'(r);
      top_col  = lfss_pkg::POS_W'(c);
    end
    res.side      = side;
    res.done      = (r == 0 && c == 0);
    if (c == 0) begin
      c = cols - 1;
      r = (r == 0) ? rows - 1 : r - 1;
    end else begin
      c = c - 1;
    end
    scan_row      = r;
    scan_col      = c;
    res.best_side = top_side;
    res.best_row  = top_row;
    res.best_col  = top_col;
    return res;
  endfunction

  // Directed table builders
  function automatic void add_cfg(input logic [lfss_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lfss_pkg::CFG_DATA_W-1:0] data);
    dir_step_t s;
    s.kind  = STEP_CFG;
    s.idx   = idx;
    s.data  = data;
    s.free  = 1'b0;
    s.typed = 1'b0;
    s.want  = '0;
    dir_steps.push_back(s);
  endfunction

  function automatic void add_cell(input logic free);
    dir_step_t s;
    s.kind  = STEP_CELL;
    s.idx   = lfss_pkg::REG_ROWS_IN_USE;
    s.data  = '0;
    s.free  = free;
    s.typed = 1'b0;
    s.want  = '0;
    dir_steps.push_back(s);
  endfunction

  function automatic void add_known(input logic free, input int side, input int bside,
                                    input int brow, input int bcol, input bit done);
    dir_step_t s;
    s.kind           = STEP_CELL;
    s.idx            = lfss_pkg::REG_ROWS_IN_USE;
    s.data           = '0;
    s.free           = free;
    s.typed          = 1'b1;
    s.want.side      = lfss_pkg::SIDE_W'(side);
    s.want.best_side = lfss_pkg::SIDE_W'(bside);
    s.want.best_row  = lfss_pkg::POS_W'(brow);
    s.want.best_col  = lfss_pkg::POS_W'(bcol);
    s.want.done      = done;
    dir_steps.push_back(s);
  endfunction

  // Write one register once the block has gone quiet
  task automatic cfg_write(input logic [lfss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfss_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lfss_pkg::REG_ROWS_IN_USE) begin
      map_rows_raw = data;
      restart_scan();
    end else if (idx == lfss_pkg::REG_COLS_IN_USE) begin
      map_cols_raw = data;
      restart_scan();
    end
  endtask

  // Send one cell beat; sender runs in bursts with gaps between them
  task automatic send_cell(input logic free, input bit typed, input square_res_t want);
    int          gap;
    square_res_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cell_free <= free;
    do @(posedge clk); while (in_stall);
    predicted = next_square(free);
    pending_squares.push_back(typed ? want : predicted);
    cells_sent++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stall: modes of random length, including stretches with no stall
  initial begin
    out_stall    <= 1'b0;
    stall_left   = 0;
    stall_tick   = 0;
    stall_period = 2;
    stall_mode   = STALL_NONE;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode   = stall_mode_e'($urandom_range(0, 3));
        stall_left   = $urandom_range(16, 200);
        stall_period = $urandom_range(2, 7);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_tick % stall_period) == 0);
      endcase
    end
  end

  // Result checker: each accepted beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_square.side      = out_cell_side;
      seen_square.best_side = out_best_side;
      seen_square.best_row  = out_best_row;
      seen_square.best_col  = out_best_col;
      seen_square.done      = out_map_done;
      if (pending_squares.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d: no cell pending, got side %0d best %0d at (%0d,%0d) done %0b",
                   results_seen, seen_square.side, seen_square.best_side,
                   seen_square.best_row, seen_square.best_col, seen_square.done);
        mismatches++;
      end else begin
        head_square = pending_squares.pop_front();
        if (seen_square.side !== head_square.side ||
            seen_square.best_side !== head_square.best_side ||
            seen_square.best_row !== head_square.best_row ||
            seen_square.best_col !== head_square.best_col ||
            seen_square.done !== head_square.done) begin
          if (mismatches < 10) begin
            $write("result %0d: want side %0d best %0d at (%0d,%0d) done %0b, ",
                   results_seen, head_square.side, head_square.best_side,
                   head_square.best_row, head_square.best_col, head_square.done);
            $display("got side %0d best %0d at (%0d,%0d) done %0b",
                     seen_square.side, seen_square.best_side,
                     seen_square.best_row, seen_square.best_col, seen_square.done);
          end
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  // Hard stop
  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("tb_largest_free_square_scan: errors");
    $finish;
  end

  // Stimulus
  initial begin
    int                             rows_w;
    int                             cols_w;
    int                             maps;
    int                             density;
    int                             n;
    int                             i;
    int                             k;
    int                             phase;
    int                             target;
    logic [lfss_pkg::CFG_IDX_W-1:0] junk_idx;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= lfss_pkg::REG_ROWS_IN_USE;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_cell_free <= 1'b0;

    cells_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    burst_left   = 0;

    // predictor at reset: full-size map, scan at bottom right
    map_rows_raw = 11'd1024;
    map_cols_raw = 11'd1024;
    foreach (below_side[j]) below_side[j] = '0;
    right_side = '0;
    diag_side  = '0;
    top_side   = '0;
    top_row    = '0;
    top_col    = '0;
    restart_scan();

    // after reset the scan starts at row 1023, column 1023
    add_known(1'b1, 1, 1, 1023, 1023, 1'b0);
    add_known(1'b0, 0, 1, 1023, 1023, 1'b0);   // obstacle leaves best alone
    add_known(1'b1, 1, 1, 1023, 1021, 1'b0);   // tie goes to later cell
    // zero counts as one: single-cell map, every beat ends a map
    add_cfg(lfss_pkg::REG_ROWS_IN_USE, 11'd0);
    add_cfg(lfss_pkg::REG_COLS_IN_USE, 11'd0);
    add_known(1'b1, 1, 1, 0, 0, 1'b1);
    add_known(1'b0, 0, 0, 0, 0, 1'b1);         // wrap clears the best
    // writes to indexes with no register do nothing
    add_cfg(REG_LAST_UNUSED, 11'h7FF);
    add_cfg(REG_FIRST_UNUSED, 11'h555);
    add_known(1'b1, 1, 1, 0, 0, 1'b1);
    // oversize row count clamps to the maximum, one column
    add_cfg(lfss_pkg::REG_ROWS_IN_USE, 11'h7FF);
    add_cfg(lfss_pkg::REG_COLS_IN_USE, 11'd1);
    add_known(1'b1, 1, 1, 1023, 0, 1'b0);
    add_known(1'b1, 1, 1, 1022, 0, 1'b0);
    // 2 x 2 all free: corner reaches 2
    add_cfg(lfss_pkg::REG_ROWS_IN_USE, 11'd2);
    add_cfg(lfss_pkg::REG_COLS_IN_USE, 11'd2);
    repeat (4) add_cell(1'b1);
    // 3 x 3 with a hole in the middle, then wrap into the next map
    add_cfg(lfss_pkg::REG_ROWS_IN_USE, 11'd3);
    add_cfg(lfss_pkg::REG_COLS_IN_USE, 11'd3);
    add_cell(1'b1); add_cell(1'b1); add_cell(1'b1);
    add_cell(1'b1); add_cell(1'b0); add_cell(1'b1);
    add_cell(1'b1); add_cell(1'b1); add_cell(1'b1);
    add_cell(1'b1); add_cell(1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[j]) begin
      if (dir_steps[j].kind == STEP_CFG) cfg_write(dir_steps[j].idx, dir_steps[j].data);
      else send_cell(dir_steps[j].free, dir_steps[j].typed, dir_steps[j].want);
    end

    // Random maps: one wide single row, one tall narrow strip, then mostly small maps
    target = cells_sent + RANDOM_CELLS;
    phase  = 0;
    while (cells_sent < target) begin
      maps = $urandom_range(1, 3);
      case ($urandom_range(0, 3))
        0:       density = 50;
        1:       density = 80;
        2:       density = 95;
        default: density = 100;
      endcase
      if (phase == 0) begin
        rows_w = 1;
        case ($urandom_range(0, 2))
          0:       cols_w = 1024;
          1:       cols_w = 2047;
          default: cols_w = 1500;
        endcase
        maps = 1;
      end else if (phase == 1) begin
        rows_w = $urandom_range(150, 260);
        cols_w = $urandom_range(1, 2);
        maps   = 1;
      end else if ($urandom_range(0, 5) == 0) begin
        rows_w = $urandom_range(1, 24);
        cols_w = $urandom_range(1, 24);
        maps   = 1;
      end else begin
        rows_w = $urandom_range(1, 8);
        cols_w = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) rows_w = 0;
        if ($urandom_range(0, 9) == 0) cols_w = 0;
      end

      if ($urandom_range(0, 5) == 0) begin
        junk_idx = lfss_pkg::CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNUSED),
                                                       int'(REG_LAST_UNUSED)));
        cfg_write(junk_idx, lfss_pkg::CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(lfss_pkg::REG_ROWS_IN_USE, lfss_pkg::CFG_DATA_W'(rows_w));
        cfg_write(lfss_pkg::REG_COLS_IN_USE, lfss_pkg::CFG_DATA_W'(cols_w));
      end else begin
        cfg_write(lfss_pkg::REG_COLS_IN_USE, lfss_pkg::CFG_DATA_W'(cols_w));
        cfg_write(lfss_pkg::REG_ROWS_IN_USE, lfss_pkg::CFG_DATA_W'(rows_w));
      end

      n = clamp_dim(map_rows_raw, MAP_MAX_ROWS) * clamp_dim(map_cols_raw, MAP_MAX_COLS) * maps;
      // now and then abandon a map part way through
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      for (i = 0; i < n && cells_sent < target; i++)
        send_cell($urandom_range(1, 100) <= density, 1'b0, '0);
      phase++;
    end

    // Wait for the tail of results, then a few quiet cycles
    in_valid <= 1'b0;
    for (k = 0; k < DRAIN_CYCLES && pending_squares.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    mismatches += pending_squares.size();
    if (mismatches == 0)
      $display("tb_largest_free_square_scan: clean");
    else
      $display("tb_largest_free_square_scan: errors");
    $finish;
  end

endmodule
